// ----- rtl/pnz_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pnz_pkg;

   localparam int unsigned RomDepth = 257;
   localparam int unsigned RomAddrW = $clog2(RomDepth);

   typedef logic [RomAddrW-1:0] rom_addr_type;
   typedef logic [7:0]          byte_type;

   // Hash permutation; the last entry repeats the first so idx+1 never wraps.
   localparam byte_type PERM_ROM [RomDepth] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,
      8'd131, 8'd13,  8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,  8'd37,  8'd240,
      8'd21,  8'd10,  8'd23,
      8'd190, 8'd6,   8'd148, 8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197,
      8'd62,  8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,  8'd57,
      8'd177, 8'd33,
      8'd88,  8'd237, 8'd149, 8'd56,  8'd87,  8'd174, 8'd20,  8'd125, 8'd136, 8'd171,
      8'd168, 8'd68,  8'd175, 8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,
      8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122, 8'd60,  8'd211,
      8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,  8'd55,  8'd46,  8'd245, 8'd40,
      8'd244,
      8'd102, 8'd143, 8'd54,  8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,
      8'd73,  8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169, 8'd200,
      8'd196,
      8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,  8'd164, 8'd100, 8'd109, 8'd198,
      8'd173, 8'd186, 8'd3,   8'd64,  8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123,
      8'd5,   8'd202, 8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,  8'd182, 8'd189,
      8'd28,  8'd42,
      8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154,
      8'd163, 8'd70,  8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110, 8'd79,  8'd113,
      8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104, 8'd218, 8'd246, 8'd97,  8'd228,
      8'd251, 8'd34,  8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179,
      8'd162, 8'd241, 8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84,
      8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,  8'd127, 8'd4,   8'd150, 8'd254,
      8'd138, 8'd236, 8'd205, 8'd93,  8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,
      8'd243, 8'd141, 8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180,
      8'd151
   };

   // Addresses past the last entry cannot occur; they read the last entry.
   function automatic byte_type perm_read(input rom_addr_type idx);
      byte_type val;
      if (idx >= rom_addr_type'(RomDepth - 1)) begin
         val = PERM_ROM[RomDepth-1];
      end else begin
         val = PERM_ROM[idx];
      end
      return val;
   endfunction

   // Upper byte of an unsigned 8x8 product.
   function automatic byte_type mul_hi8(input byte_type a, input byte_type b);
      logic [15:0] prod;
      prod = {8'h00, a} * {8'h00, b};
      return prod[15:8];
   endfunction

   // Gradient: bit 2 swaps, bit 0 negates s, bit 1 negates r; (s + r) >>> 1.
   function automatic byte_type corner_grad(input byte_type h, input byte_type p,
                                            input byte_type q);
      byte_type   s;
      byte_type   r;
      logic [8:0] sum;
      s   = h[2] ? q : p;
      r   = h[2] ? p : q;
      s   = h[0] ? 8'(8'h00 - s) : s;
      r   = h[1] ? 8'(8'h00 - r) : r;
      sum = {s[7], s} + {r[7], r};
      return sum[8:1];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/pnz_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Signed lerp a -> b by f, three stages: compare/diff, multiply, add.
module pnz_blend (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire pnz_pkg::byte_type   a,
   input  wire pnz_pkg::byte_type   b,
   input  wire pnz_pkg::byte_type   f,
   output logic                     out_valid,
   output pnz_pkg::byte_type        result
);

   logic              gt_in;
   pnz_pkg::byte_type diff_in;
   pnz_pkg::byte_type hi_in;
   pnz_pkg::byte_type res_in;

   logic              v1_ff, v2_ff, v3_ff;
   logic              gt1_ff, gt2_ff;
   pnz_pkg::byte_type a1_ff, a2_ff;
   pnz_pkg::byte_type diff1_ff, f1_ff, hi2_ff, res_ff;

   always_comb begin
      gt_in   = $signed(b) > $signed(a);
      diff_in = gt_in ? 8'(b - a) : 8'(a - b);
      hi_in   = pnz_pkg::mul_hi8(diff1_ff, f1_ff);
      res_in  = gt2_ff ? 8'(a2_ff + hi2_ff) : 8'(a2_ff - hi2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff    <= a;
      gt1_ff   <= gt_in;
      diff1_ff <= diff_in;
      f1_ff    <= f;
      a2_ff    <= a1_ff;
      gt2_ff   <= gt1_ff;
      hi2_ff   <= hi_in;
      res_ff   <= res_in;
   end

   assign out_valid = v3_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

// ----- rtl/perlin_noise_2d_8bit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// 2D Perlin-style noise, 8-bit. A request (req_coord_x, req_coord_y) is taken
// on every clock edge where start is high; busy is always low, so a new
// coordinate can enter every cycle. Each request gives exactly one result,
// in request order, on rsp_noise_value with rsp_valid high for one cycle.
// The receiver cannot stall the output and does not need to: the pipeline
// never holds items back. Throughput is one sample per clock; the datapath
// has 9 stages (two hash ROM stages, a gradient stage, and two 3-stage lerp
// rounds: two blend units for x, one for y, each around one 8x8 multiply).
// High byte of each coordinate selects the lattice cell, low byte the
// position in it. The block has no state besides its pipeline registers.
module perlin_noise_2d_8bit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [15:0]        req_coord_x,
   input  wire logic [15:0]        req_coord_y,
   output logic                    rsp_valid,
   output logic signed [7:0]       rsp_noise_value
);

   localparam pnz_pkg::byte_type NoiseBias = 8'd64;

   // ---------------- stage 1: first hash level, ease multiply ----------------
   logic              accept;
   pnz_pkg::byte_type ha_in, hb_in;
   pnz_pkg::byte_type mx_in, my_in;
   pnz_pkg::byte_type sqx_in, sqy_in;

   logic              v1_ff;
   pnz_pkg::byte_type ha1_ff, hb1_ff, fx1_ff, fy1_ff, sqx1_ff, sqy1_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      ha_in  = 8'(pnz_pkg::perm_read({1'b0, req_coord_x[15:8]}) + req_coord_y[15:8]);
      hb_in  = 8'(pnz_pkg::perm_read(9'({1'b0, req_coord_x[15:8]} + 9'd1))
                  + req_coord_y[15:8]);
      // fold the upper half of the curve: 255 - t
      mx_in  = req_coord_x[7] ? ~req_coord_x[7:0] : req_coord_x[7:0];
      my_in  = req_coord_y[7] ? ~req_coord_y[7:0] : req_coord_y[7:0];
      sqx_in = pnz_pkg::mul_hi8(mx_in, mx_in);
      sqy_in = pnz_pkg::mul_hi8(my_in, my_in);
   end

   // ---------------- stage 2: corner hashes, finish ease ----------------
   pnz_pkg::byte_type haa_in, hab_in, hba_in, hbb_in;
   pnz_pkg::byte_type eu_in, ev_in;

   logic              v2_ff;
   pnz_pkg::byte_type haa2_ff, hab2_ff, hba2_ff, hbb2_ff, eu2_ff, ev2_ff;
   logic [6:0]        px2_ff, py2_ff;

   always_comb begin
      haa_in = pnz_pkg::perm_read({1'b0, ha1_ff});
      hab_in = pnz_pkg::perm_read(9'({1'b0, ha1_ff} + 9'd1));
      hba_in = pnz_pkg::perm_read({1'b0, hb1_ff});
      hbb_in = pnz_pkg::perm_read(9'({1'b0, hb1_ff} + 9'd1));
      eu_in  = fx1_ff[7] ? ~{sqx1_ff[6:0], 1'b0} : {sqx1_ff[6:0], 1'b0};
      ev_in  = fy1_ff[7] ? ~{sqy1_ff[6:0], 1'b0} : {sqy1_ff[6:0], 1'b0};
   end

   // ---------------- stage 3: gradients ----------------
   // Offsets: p = frac >> 1, and p - 128 is the same bits with the top set.
   pnz_pkg::byte_type g1_in, g2_in, g3_in, g4_in;

   logic              v3_ff;
   pnz_pkg::byte_type g1_ff, g2_ff, g3_ff, g4_ff, eu3_ff, ev3_ff;

   always_comb begin
      g1_in = pnz_pkg::corner_grad(pnz_pkg::perm_read({1'b0, haa2_ff}),
                                   {1'b0, px2_ff}, {1'b0, py2_ff});
      g2_in = pnz_pkg::corner_grad(pnz_pkg::perm_read({1'b0, hba2_ff}),
                                   {1'b1, px2_ff}, {1'b0, py2_ff});
      g3_in = pnz_pkg::corner_grad(pnz_pkg::perm_read({1'b0, hab2_ff}),
                                   {1'b0, px2_ff}, {1'b1, py2_ff});
      g4_in = pnz_pkg::corner_grad(pnz_pkg::perm_read({1'b0, hbb2_ff}),
                                   {1'b1, px2_ff}, {1'b1, py2_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ha1_ff  <= ha_in;
      hb1_ff  <= hb_in;
      fx1_ff  <= req_coord_x[7:0];
      fy1_ff  <= req_coord_y[7:0];
      sqx1_ff <= sqx_in;
      sqy1_ff <= sqy_in;

      haa2_ff <= haa_in;
      hab2_ff <= hab_in;
      hba2_ff <= hba_in;
      hbb2_ff <= hbb_in;
      eu2_ff  <= eu_in;
      ev2_ff  <= ev_in;
      px2_ff  <= fx1_ff[7:1];
      py2_ff  <= fy1_ff[7:1];

      g1_ff   <= g1_in;
      g2_ff   <= g2_in;
      g3_ff   <= g3_in;
      g4_ff   <= g4_in;
      eu3_ff  <= eu2_ff;
      ev3_ff  <= ev2_ff;
   end

   // ---------------- stages 4-6: blend along x ----------------
   logic              row0_valid, row1_valid;
   pnz_pkg::byte_type row0, row1;
   pnz_pkg::byte_type ev4_ff, ev5_ff, ev6_ff;

   pnz_blend u_row0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .a         (g1_ff),
      .b         (g2_ff),
      .f         (eu3_ff),
      .out_valid (row0_valid),
      .result    (row0)
   );

   pnz_blend u_row1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .a         (g3_ff),
      .b         (g4_ff),
      .f         (eu3_ff),
      .out_valid (row1_valid),
      .result    (row1)
   );

   // y weight rides alongside the x blends
   always_ff @(posedge clock) begin
      ev4_ff <= ev3_ff;
      ev5_ff <= ev4_ff;
      ev6_ff <= ev5_ff;
   end

   // ---------------- stages 7-9: blend along y ----------------
   logic              fin_valid;
   pnz_pkg::byte_type fin;

   pnz_blend u_col (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row0_valid && row1_valid),
      .a         (row0),
      .b         (row1),
      .f         (ev6_ff),
      .out_valid (fin_valid),
      .result    (fin)
   );

   assign rsp_valid       = fin_valid;
   assign rsp_noise_value = $signed(8'(fin + NoiseBias));

endmodule

`default_nettype wire

// ----- rtl/pnz_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pnz_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [15:0]       req_coord_x,
   input wire logic [15:0]       req_coord_y,
   input wire logic              rsp_valid,
   input wire logic signed [7:0] rsp_noise_value
);

   localparam int Latency = 9;

   logic accept;
   assign accept = start && !busy;

   // pipeline never pushes back
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy asserted");

   // every request answered after the fixed latency
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##9 rsp_valid)
      else $error("request lost");

   // no result without a request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, Latency))
      else $error("spurious result");

   // identical back-to-back requests give identical results
   a_same_in_same_out: assert property (@(posedge clock) disable iff (reset)
      (accept && $past(accept) && !$past(reset)
       && $stable(req_coord_x) && $stable(req_coord_y))
      |-> ##9 (rsp_noise_value == $past(rsp_noise_value)))
      else $error("result differs for identical request");

endmodule

bind perlin_noise_2d_8bit pnz_checker u_pnz_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_coord_x     (req_coord_x),
   .req_coord_y     (req_coord_y),
   .rsp_valid       (rsp_valid),
   .rsp_noise_value (rsp_noise_value)
);

`default_nettype wire
